[src/dnsa_pkg.sv]
package dnsa_pkg;

    // Bytes at this position and later are ignored until the last byte.
    localparam int MAX_PACKET_BYTES = 512;
    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

    // Header byte positions.
    localparam logic [CNT_W-1:0] HDR_ID_HI  = CNT_W'(0);
    localparam logic [CNT_W-1:0] HDR_ID_LO  = CNT_W'(1);
    localparam logic [CNT_W-1:0] HDR_QD_HI  = CNT_W'(4);
    localparam logic [CNT_W-1:0] HDR_QD_LO  = CNT_W'(5);
    localparam logic [CNT_W-1:0] HDR_AN_HI  = CNT_W'(6);
    localparam logic [CNT_W-1:0] HDR_AN_LO  = CNT_W'(7);
    localparam logic [CNT_W-1:0] HDR_LAST   = CNT_W'(11);
    localparam logic [CNT_W-1:0] CNT_LIMIT  = CNT_W'(MAX_PACKET_BYTES);

    // Answer record header byte positions.
    localparam logic [3:0] REC_TYPE_HI = 4'd2;
    localparam logic [3:0] REC_TYPE_LO = 4'd3;
    localparam logic [3:0] REC_LEN_HI  = 4'd10;
    localparam logic [3:0] REC_LEN_LO  = 4'd11;
    localparam logic [3:0] REC_HDR_LEN = 4'd12;
    localparam logic [3:0] ADDR_BYTES  = 4'd4;

    // Name compression pointer marker and fixed question tail length.
    localparam logic [7:0]  PTR_MASK   = 8'hC0;
    localparam logic [15:0] QFIXED_LEN = 16'd4;
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] A_RDLEN    = 16'd4;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QLABEL = 4'd2,
        PH_QPTR   = 4'd3,
        PH_QFIXED = 4'd4,
        PH_AHDR   = 4'd5,
        PH_ADDR   = 4'd6,
        PH_RSKIP  = 4'd7,
        PH_DONE   = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND = 3'd0,
        ST_SHORT = 3'd1,
        ST_NOANS = 3'd2,
        ST_TRUNC = 3'd3,
        ST_NOA   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [31:0] address;
        logic [15:0] transaction_id;
    } t_out_item;

endpackage

[src/dnsa_in_stage.sv]
module dnsa_in_stage
    import dnsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_out_free,
    output logic     o_take,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // A non-final byte never waits; the final byte needs room for its result.
    assign o_take  = r_valid && (!r_item.last_byte || i_out_free);
    assign o_ready = !r_valid || o_take;
    assign o_item  = r_item;

    // Valid flag of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload of the input register.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[src/dnsa_parser.sv]
module dnsa_parser
    import dnsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]      r_questions_left, n_questions_left;
    logic [15:0]      r_answers_left, n_answers_left;
    logic [15:0]      r_skip_left, n_skip_left;
    logic [3:0]       r_field_index, n_field_index;
    logic [15:0]      r_record_type, n_record_type;
    logic [15:0]      r_record_length, n_record_length;
    logic [31:0]      r_address_hold, n_address_hold;
    logic [15:0]      r_id_hold, n_id_hold;
    t_status          r_result_code, n_result_code;

    // Parse state after the current byte, before any end-of-packet clear.
    t_phase           p_phase;
    logic [15:0]      p_questions_left;
    logic [15:0]      p_answers_left;
    logic [15:0]      p_skip_left;
    logic [3:0]       p_field_index;
    logic [15:0]      p_record_type;
    logic [15:0]      p_record_length;
    logic [31:0]      p_address_hold;
    logic [15:0]      p_id_hold;
    t_status          p_result_code;
    t_status          close_status;
    logic [7:0]       b;
    logic [15:0]      q_dec;
    logic [3:0]       f_inc;

    assign b = i_item.data_byte;

    // Per-byte parser step.
    always_comb begin
        p_phase          = r_phase;
        p_questions_left = r_questions_left;
        p_answers_left   = r_answers_left;
        p_skip_left      = r_skip_left;
        p_field_index    = r_field_index;
        p_record_type    = r_record_type;
        p_record_length  = r_record_length;
        p_address_hold   = r_address_hold;
        p_id_hold        = r_id_hold;
        p_result_code    = r_result_code;
        q_dec            = r_questions_left - 16'd1;
        f_inc            = r_field_index + 4'd1;
        n_byte_count     = r_byte_count;

        if (r_byte_count < CNT_LIMIT) begin
            n_byte_count = r_byte_count + CNT_W'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (r_byte_count == HDR_ID_HI) begin
                        p_id_hold = {b, 8'h00};
                    end else if (r_byte_count == HDR_ID_LO) begin
                        p_id_hold = {r_id_hold[15:8], b};
                    end else if (r_byte_count == HDR_QD_HI) begin
                        p_questions_left = {b, 8'h00};
                    end else if (r_byte_count == HDR_QD_LO) begin
                        p_questions_left = {r_questions_left[15:8], b};
                    end else if (r_byte_count == HDR_AN_HI) begin
                        p_answers_left = {b, 8'h00};
                    end else if (r_byte_count == HDR_AN_LO) begin
                        p_answers_left = {r_answers_left[15:8], b};
                    end
                    if (r_byte_count == HDR_LAST) begin
                        if (r_answers_left == 16'd0) begin
                            p_phase       = PH_DONE;
                            p_result_code = ST_NOANS;
                        end else if (r_questions_left == 16'd0) begin
                            p_phase       = PH_AHDR;
                            p_field_index = 4'd0;
                        end else begin
                            p_phase = PH_QNAME;
                        end
                    end
                end
                PH_QNAME: begin
                    if (b == 8'd0) begin
                        p_phase     = PH_QFIXED;
                        p_skip_left = QFIXED_LEN;
                    end else if ((b & PTR_MASK) == PTR_MASK) begin
                        p_phase = PH_QPTR;
                    end else begin
                        p_phase     = PH_QLABEL;
                        p_skip_left = {8'h00, b};
                    end
                end
                PH_QLABEL: begin
                    p_skip_left = r_skip_left - 16'd1;
                    if (p_skip_left == 16'd0) begin
                        p_phase = PH_QNAME;
                    end
                end
                PH_QPTR: begin
                    p_phase     = PH_QFIXED;
                    p_skip_left = QFIXED_LEN;
                end
                PH_QFIXED: begin
                    p_skip_left = r_skip_left - 16'd1;
                    if (p_skip_left == 16'd0) begin
                        p_questions_left = q_dec;
                        if (q_dec == 16'd0) begin
                            p_phase       = PH_AHDR;
                            p_field_index = 4'd0;
                        end else begin
                            p_phase = PH_QNAME;
                        end
                    end
                end
                PH_AHDR: begin
                    if (r_field_index == REC_TYPE_HI) begin
                        p_record_type = {b, 8'h00};
                    end else if (r_field_index == REC_TYPE_LO) begin
                        p_record_type = {r_record_type[15:8], b};
                    end else if (r_field_index == REC_LEN_HI) begin
                        p_record_length = {b, 8'h00};
                    end else if (r_field_index == REC_LEN_LO) begin
                        p_record_length = {r_record_length[15:8], b};
                    end
                    p_field_index = f_inc;
                    if (f_inc == REC_HDR_LEN) begin
                        p_answers_left = r_answers_left - 16'd1;
                        if (p_record_type == TYPE_A && p_record_length == A_RDLEN) begin
                            p_phase        = PH_ADDR;
                            p_field_index  = 4'd0;
                            p_address_hold = 32'd0;
                        end else if (p_answers_left == 16'd0) begin
                            p_phase       = PH_DONE;
                            p_result_code = ST_NOA;
                        end else if (p_record_length == 16'd0) begin
                            p_field_index = 4'd0;
                        end else begin
                            p_phase     = PH_RSKIP;
                            p_skip_left = p_record_length;
                        end
                    end
                end
                PH_ADDR: begin
                    p_address_hold = {r_address_hold[23:0], b};
                    p_field_index  = f_inc;
                    if (f_inc == ADDR_BYTES) begin
                        p_phase       = PH_DONE;
                        p_result_code = ST_FOUND;
                    end
                end
                PH_RSKIP: begin
                    p_skip_left = r_skip_left - 16'd1;
                    if (p_skip_left == 16'd0) begin
                        p_phase       = PH_AHDR;
                        p_field_index = 4'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Status reported when the packet closes.
    always_comb begin
        case (p_phase)
            PH_DONE:   close_status = p_result_code;
            PH_HEADER: close_status = ST_SHORT;
            PH_ADDR,
            PH_RSKIP:  close_status = (p_answers_left != 16'd0) ? ST_TRUNC : ST_NOA;
            default:   close_status = ST_TRUNC;
        endcase
    end

    // Result of a closing byte.
    assign o_res_valid          = i_take && i_item.last_byte;
    assign o_res.status         = close_status;
    assign o_res.found          = (close_status == ST_FOUND) && (p_address_hold != 32'd0);
    assign o_res.address        = (close_status == ST_FOUND) ? p_address_hold : 32'd0;
    assign o_res.transaction_id = p_id_hold;

    // Next register values: the last byte returns everything to reset.
    always_comb begin
        if (i_item.last_byte) begin
            n_phase          = PH_HEADER;
            n_questions_left = 16'd0;
            n_answers_left   = 16'd0;
            n_skip_left      = 16'd0;
            n_field_index    = 4'd0;
            n_record_type    = 16'd0;
            n_record_length  = 16'd0;
            n_address_hold   = 32'd0;
            n_id_hold        = 16'd0;
            n_result_code    = ST_FOUND;
        end else begin
            n_phase          = p_phase;
            n_questions_left = p_questions_left;
            n_answers_left   = p_answers_left;
            n_skip_left      = p_skip_left;
            n_field_index    = p_field_index;
            n_record_type    = p_record_type;
            n_record_length  = p_record_length;
            n_address_hold   = p_address_hold;
            n_id_hold        = p_id_hold;
            n_result_code    = p_result_code;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HEADER;
            r_byte_count     <= '0;
            r_questions_left <= 16'd0;
            r_answers_left   <= 16'd0;
            r_skip_left      <= 16'd0;
            r_field_index    <= 4'd0;
            r_record_type    <= 16'd0;
            r_record_length  <= 16'd0;
            r_address_hold   <= 32'd0;
            r_id_hold        <= 16'd0;
            r_result_code    <= ST_FOUND;
        end else if (i_take) begin
            r_phase          <= n_phase;
            r_byte_count     <= i_item.last_byte ? '0 : n_byte_count;
            r_questions_left <= n_questions_left;
            r_answers_left   <= n_answers_left;
            r_skip_left      <= n_skip_left;
            r_field_index    <= n_field_index;
            r_record_type    <= n_record_type;
            r_record_length  <= n_record_length;
            r_address_hold   <= n_address_hold;
            r_id_hold        <= n_id_hold;
            r_result_code    <= n_result_code;
        end
    end

endmodule

[src/dnsa_out_stage.sv]
module dnsa_out_stage
    import dnsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_item i_res,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;

    // The register can take a new result when empty or being drained.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    // Payload of the result register.
    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_item <= i_res;
        end
    end

endmodule

[src/dns_response_a_record_extractor.sv]
// DNS response A-record extractor.
// The input channel (i_in_valid, o_in_ready, i_in_item) carries one packet
// byte per item, with last_byte set on the final byte of a packet. The output
// channel (o_out_valid, i_out_ready, o_out_item) carries one result item per
// packet: status, found flag, IPv4 address and transaction id.
// Each byte is registered, parsed by single-pass logic, and the result of the
// final byte lands in an output register. One byte is taken every cycle
// unless a final byte waits for the output register; the rate is set by the
// input register feeding the parser in a single step.
// While the receiver stalls, non-final bytes keep flowing into the parser.
// A final byte waits in the input register until the output register is free,
// and the input then stalls behind it.
// Bytes at or beyond the packet capacity are ignored until the final byte.
// Reset empties both registers and returns the parser to the start of the
// header; after each final byte the parser also returns to that state.
module dns_response_a_record_extractor
    import dnsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      out_free;
    logic      take;
    t_in_item  cur_item;
    logic      res_valid;
    t_out_item res;

    // Input register.
    dnsa_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_item     (i_in_item),
        .i_out_free (out_free),
        .o_take     (take),
        .o_item     (cur_item)
    );

    // Byte parser.
    dnsa_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (cur_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    dnsa_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out_item)
    );

endmodule

[dv/dns_a_record_result_checker.sv]
module dns_a_record_result_checker
    import dnsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_results_pending
);

    // Parser state mirrored from the block's behavior.
    t_phase      ph;
    t_status     code;
    logic [15:0] pkt_bytes;
    logic [15:0] q_left;
    logic [15:0] a_left;
    logic [15:0] skip_cnt;
    logic [3:0]  fidx;
    logic [15:0] rtype;
    logic [15:0] rlen;
    logic [31:0] addr;
    logic [15:0] tid;

    // Results predicted for packets whose final byte has been accepted.
    t_out_item expected_results[$];
    int        fails = 0;

    // Return the parser to the start of the header.
    function automatic void parser_clear();
        ph        = PH_HEADER;
        code      = ST_FOUND;
        pkt_bytes = '0;
        q_left    = '0;
        a_left    = '0;
        skip_cnt  = '0;
        fidx      = '0;
        rtype     = '0;
        rlen      = '0;
        addr      = '0;
        tid       = '0;
    endfunction

    // A decision has been made; the rest of the packet is ignored.
    function automatic void close_with(t_status s);
        ph   = PH_DONE;
        code = s;
    endfunction

    function automatic void question_done();
        q_left = q_left - 16'd1;
        if (q_left == 0) begin
            ph   = PH_AHDR;
            fidx = '0;
        end else begin
            ph = PH_QNAME;
        end
    endfunction

    // Advance the parser by one counted packet byte.
    function automatic void consume(logic [7:0] b);
        case (ph)
            PH_HEADER: begin
                if (pkt_bytes == HDR_ID_HI) tid = {b, 8'h00};
                else if (pkt_bytes == HDR_ID_LO) tid = {tid[15:8], b};
                else if (pkt_bytes == HDR_QD_HI) q_left = {b, 8'h00};
                else if (pkt_bytes == HDR_QD_LO) q_left = {q_left[15:8], b};
                else if (pkt_bytes == HDR_AN_HI) a_left = {b, 8'h00};
                else if (pkt_bytes == HDR_AN_LO) a_left = {a_left[15:8], b};
                if (pkt_bytes == HDR_LAST) begin
                    if (a_left == 0) begin
                        close_with(ST_NOANS);
                    end else if (q_left == 0) begin
                        ph   = PH_AHDR;
                        fidx = '0;
                    end else begin
                        ph = PH_QNAME;
                    end
                end
            end
            PH_QNAME: begin
                if (b == 8'h00) begin
                    ph       = PH_QFIXED;
                    skip_cnt = QFIXED_LEN;
                end else if ((b & PTR_MASK) == PTR_MASK) begin
                    ph = PH_QPTR;
                end else begin
                    ph       = PH_QLABEL;
                    skip_cnt = {8'h00, b};
                end
            end
            PH_QLABEL: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) ph = PH_QNAME;
            end
            PH_QPTR: begin
                // A pointer ends the name; no terminator follows it.
                ph       = PH_QFIXED;
                skip_cnt = QFIXED_LEN;
            end
            PH_QFIXED: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) question_done();
            end
            PH_AHDR: begin
                if (fidx == REC_TYPE_HI) rtype = {b, 8'h00};
                else if (fidx == REC_TYPE_LO) rtype = {rtype[15:8], b};
                else if (fidx == REC_LEN_HI) rlen = {b, 8'h00};
                else if (fidx == REC_LEN_LO) rlen = {rlen[15:8], b};
                fidx = fidx + 4'd1;
                if (fidx == REC_HDR_LEN) begin
                    a_left = a_left - 16'd1;
                    if (rtype == TYPE_A && rlen == A_RDLEN) begin
                        ph   = PH_ADDR;
                        fidx = '0;
                        addr = '0;
                    end else if (a_left == 0) begin
                        close_with(ST_NOA);
                    end else if (rlen == 0) begin
                        fidx = '0;
                    end else begin
                        ph       = PH_RSKIP;
                        skip_cnt = rlen;
                    end
                end
            end
            PH_ADDR: begin
                addr = {addr[23:0], b};
                fidx = fidx + 4'd1;
                if (fidx == ADDR_BYTES) close_with(ST_FOUND);
            end
            PH_RSKIP: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) begin
                    ph   = PH_AHDR;
                    fidx = '0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Take one input item; on the final byte, build the packet's result.
    function automatic bit parse_byte(input t_in_item it, output t_out_item res);
        t_status st;
        res = '0;
        if (pkt_bytes < MAX_PACKET_BYTES) begin
            consume(it.data_byte);
            pkt_bytes = pkt_bytes + 16'd1;
        end
        if (!it.last_byte) return 1'b0;
        case (ph)
            PH_DONE:           st = code;
            PH_HEADER:         st = ST_SHORT;
            PH_ADDR, PH_RSKIP: st = (a_left != 0) ? ST_TRUNC : ST_NOA;
            default:           st = ST_TRUNC;
        endcase
        res.status         = st;
        res.found          = (st == ST_FOUND) && (addr != 0);
        res.address        = (st == ST_FOUND) ? addr : 32'h0;
        res.transaction_id = tid;
        parser_clear();
        return 1'b1;
    endfunction

    // Predict on accepted input items and compare accepted result items.
    always @(posedge i_clk) begin
        t_out_item predicted;
        t_out_item want;
        if (!i_rst_n) begin
            parser_clear();
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (parse_byte(i_in_item, predicted)) expected_results.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: status %0d id %h",
                           i_out_item.status, i_out_item.transaction_id);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               i_out_item.status);
                        fails++;
                    end
                    if (i_out_item.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found,
                               i_out_item.found);
                        fails++;
                    end
                    if (i_out_item.address !== want.address) begin
                        $error("address: expected %h, got %h", want.address,
                               i_out_item.address);
                        fails++;
                    end
                    if (i_out_item.transaction_id !== want.transaction_id) begin
                        $error("transaction_id: expected %h, got %h",
                               want.transaction_id, i_out_item.transaction_id);
                        fails++;
                    end
                end
            end
        end
        o_fail_count      <= fails;
        o_results_pending <= expected_results.size();
    end

endmodule

[dv/dns_response_a_record_extractor_tb.sv]
module dns_response_a_record_extractor_tb;
    import dnsa_pkg::*;

    // Record types used besides the address record.
    localparam int RR_CNAME = 5;
    localparam int RR_TXT   = 16;
    localparam int RR_AAAA  = 28;

    // Address record type and its rdata length as plain integers.
    localparam int RR_A     = int'(TYPE_A);
    localparam int RR_A_LEN = int'(A_RDLEN);

    // Shapes of a question name.
    typedef enum int {
        QN_POINTER,
        QN_LABELS,
        QN_LABELS_PTR,
        QN_WIDE_LABEL,
        QN_WIDER_LABEL
    } t_qname_form;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        fail_count;
    int        results_pending;
    int        bytes_taken = 0;
    logic      quiet;

    logic [7:0] pkt[$];
    int         sent_bytes = 0;

    dns_response_a_record_extractor u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    dns_a_record_result_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_in_item         (in_item),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_out_item        (out_item),
        .o_fail_count      (fail_count),
        .o_results_pending (results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Accepted input items drive the quiet window and the long hold-off.
    always @(posedge clk) begin
        if (in_valid && in_ready) bytes_taken <= bytes_taken + 1;
    end
    assign quiet = (bytes_taken >= 700) && (bytes_taken < 1100);

    // Packet assembly helpers.
    function automatic void put_byte(int v);
        pkt.push_back(8'(v));
    endfunction

    function automatic void put_word(int v);
        put_byte(v >> 8);
        put_byte(v);
    endfunction

    function automatic void put_noise(int n);
        repeat (n) put_byte($urandom_range(255));
    endfunction

    function automatic void put_header(int id, int qd, int an);
        put_word(id);
        put_noise(2);
        put_word(qd);
        put_word(an);
        put_noise(4);
    endfunction

    function automatic void put_short_labels();
        int n;
        repeat ($urandom_range(1, 3)) begin
            n = $urandom_range(1, 10);
            put_byte(n);
            put_noise(n);
        end
    endfunction

    // One question: a name of the given shape, then type and class.
    function automatic void put_question(t_qname_form form);
        case (form)
            QN_POINTER: begin
                put_byte(PTR_MASK | $urandom_range(63));
                put_noise(1);
            end
            QN_LABELS: begin
                put_short_labels();
                put_byte(0);
            end
            QN_LABELS_PTR: begin
                put_short_labels();
                put_byte(PTR_MASK | $urandom_range(63));
                put_noise(1);
            end
            QN_WIDE_LABEL: begin
                put_byte('h40);
                put_noise(64);
                put_byte(0);
            end
            default: begin
                put_byte('h80);
                put_noise(128);
                put_byte(0);
            end
        endcase
        put_noise(4);
    endfunction

    // Answer record header; the caller appends the rdata.
    function automatic void put_record(int rtype, int rdlen);
        if ($urandom_range(1)) put_word('hC00C);
        else put_noise(2);
        put_word(rtype);
        put_noise(6);
        put_word(rdlen);
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!quiet && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_bytes++;
    endtask

    // Send the assembled packet, cut to keep bytes when keep is positive.
    task automatic send_packet(int keep);
        int n;
        n = (keep > 0 && keep < pkt.size()) ? keep : pkt.size();
        for (int i = 0; i < n; i++) send_byte(pkt[i], i == n - 1);
        pkt.delete();
    endtask

    // Mostly well-formed responses with random content, some noise.
    task automatic random_packet();
        int kind;
        int qd;
        int an;
        int r;
        int cut;
        cut  = 0;
        kind = $urandom_range(99);
        if (kind < 8) begin
            put_noise($urandom_range(1, 40));
        end else begin
            r  = $urandom_range(99);
            qd = (r < 5) ? $urandom_range(65535) : $urandom_range(0, 2);
            r  = $urandom_range(99);
            an = (r < 6) ? 0 : (r < 10) ? $urandom_range(65535) : $urandom_range(1, 4);
            put_header($urandom_range(65535), qd, an);
            for (int i = 0; i < qd && i < 3; i++) begin
                r = $urandom_range(99);
                if (r < 3) put_question(QN_WIDE_LABEL);
                else if (r < 5) put_question(QN_WIDER_LABEL);
                else put_question(t_qname_form'($urandom_range(QN_POINTER, QN_LABELS_PTR)));
            end
            for (int i = 0; i < an && i < 4; i++) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    put_record(RR_A, RR_A_LEN);
                    if ($urandom_range(9) == 0) put_noise(0);
                    if ($urandom_range(9) == 0) begin
                        put_word(0);
                        put_word(0);
                    end else begin
                        put_noise(4);
                    end
                end else if (r < 55) begin
                    qd = $urandom_range(0, 8);
                    put_record(RR_A, qd);
                    put_noise(qd);
                end else if (r < 70) begin
                    qd = $urandom_range(0, 12);
                    put_record(RR_CNAME, qd);
                    put_noise(qd);
                end else if (r < 80) begin
                    put_record(RR_AAAA, 16);
                    put_noise(16);
                end else if (r < 90) begin
                    put_record($urandom_range(65535), 0);
                end else begin
                    qd = $urandom_range(0, 6);
                    put_record($urandom_range(65535), qd);
                    put_noise(qd);
                end
            end
            r = $urandom_range(99);
            if (r < 15) cut = $urandom_range(1, pkt.size());
            else if (r < 25) put_noise($urandom_range(1, 8));
            else if (r < 27 && pkt.size() < 530) put_noise(530 - pkt.size());
        end
        send_packet(cut);
    endtask

    // Result side: random stalls, one long hold-off and a stall-free window.
    initial begin : receiver
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (!hold_used && bytes_taken >= 300) begin
                hold_used = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (quiet) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 31);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // A single byte, and a header cut one byte short.
        put_byte('hFF);
        send_packet(0);
        put_header('hFFFF, 1, 1);
        send_packet(11);

        // No answers, with trailing bytes that are ignored.
        put_header(0, 3, 0);
        put_noise(5);
        send_packet(0);

        // Address of all ones, then an all-zero address.
        put_header('h8001, 0, 1);
        put_record(RR_A, RR_A_LEN);
        put_word('hFFFF);
        put_word('hFFFF);
        send_packet(0);
        put_header($urandom_range(65535), 0, 1);
        put_record(RR_A, RR_A_LEN);
        put_word(0);
        put_word(0);
        send_packet(0);

        // Pointer name with no terminator after it.
        put_header($urandom_range(65535), 1, 1);
        put_question(QN_POINTER);
        put_record(RR_A, RR_A_LEN);
        put_noise(4);
        send_packet(0);

        // Label lengths with top bits 01 and 10, labels ending in a pointer.
        put_header($urandom_range(65535), 3, 2);
        put_question(QN_WIDE_LABEL);
        put_question(QN_WIDER_LABEL);
        put_question(QN_LABELS_PTR);
        put_record(RR_CNAME, 7);
        put_noise(7);
        put_record(RR_A, RR_A_LEN);
        put_noise(4);
        send_packet(0);

        // Address record of the wrong length is the last answer.
        put_header($urandom_range(65535), 0, 1);
        put_record(RR_A, 5);
        put_noise(5);
        send_packet(0);

        // Empty records ahead of the address record.
        put_header($urandom_range(65535), 1, 3);
        put_question(QN_LABELS);
        put_record(RR_TXT, 0);
        put_record(RR_TXT, 0);
        put_record(RR_A, RR_A_LEN);
        put_noise(7);
        send_packet(0);

        // Packets that end inside a question and inside a record header.
        put_header($urandom_range(65535), 2, 1);
        put_question(QN_LABELS);
        put_question(QN_LABELS);
        send_packet(16);
        put_header($urandom_range(65535), 0, 2);
        put_record(RR_CNAME, 2);
        send_packet(18);

        // Packets that end in rdata, with and without answers left.
        put_header($urandom_range(65535), 0, 2);
        put_record(RR_CNAME, 8);
        put_noise(8);
        send_packet(27);
        put_header($urandom_range(65535), 0, 1);
        put_record(RR_A, RR_A_LEN);
        put_noise(4);
        send_packet(26);
        put_header($urandom_range(65535), 0, 2);
        put_record(RR_A, RR_A_LEN);
        put_noise(4);
        send_packet(26);

        // Largest counts, and a last answer that is not an address.
        put_header('hFFFF, 'hFFFF, 'hFFFF);
        put_question(QN_POINTER);
        put_question(QN_POINTER);
        send_packet(0);
        put_header($urandom_range(65535), 0, 1);
        put_record(RR_AAAA, 16);
        put_noise(16);
        send_packet(0);

        // Address ending on the last counted byte, then one byte past it.
        for (int k = 0; k < 2; k++) begin
            int rem;
            int len;
            put_header($urandom_range(65535), 1, 1);
            rem = 479 + k;
            while (rem > 0) begin
                len = (rem >= 66) ? 63 : (rem > 64) ? 31 : rem - 1;
                put_byte(len);
                put_noise(len);
                rem -= len + 1;
            end
            put_byte(0);
            put_noise(4);
            put_record(RR_A, RR_A_LEN);
            put_noise(4);
            send_packet(0);
        end

        // Random packets up to the item budget of the run.
        while (sent_bytes < 2000) random_packet();
        in_valid <= 1'b0;

        // Drain the outstanding results, then allow the block to settle.
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("[dns_response_a_record_extractor] OK");
        end else begin
            $display("[dns_response_a_record_extractor] ERROR");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #5_000_000;
        $display("[dns_response_a_record_extractor] ERROR");
        $finish;
    end

endmodule
